// ===== sv/nfcsa_pkg.sv =====
// Shared types, constants and helper functions of the next-fit slot allocator.
package nfcsa_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int WORD_W    = 32;
  localparam int OFF_W     = 5;
  localparam int START_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int STATUS_W  = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    logic               vld;
    status_t            status;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
  } res_t;

  // Bits lo..hi of a bitmap word set, all others clear.
  function automatic logic [WORD_W-1:0] range_mask(input logic [OFF_W-1:0] lo,
                                                   input logic [OFF_W-1:0] hi);
    logic [WORD_W-1:0] ones;
    ones = '1;
    return (ones << lo) & (ones >> (~hi));
  endfunction

  // Index of the highest set bit; zero when none is set.
  function automatic logic [OFF_W-1:0] top_bit(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (v[j]) idx = OFF_W'(j);
    end
    return idx;
  endfunction

endpackage

// ===== sv/nfcsa_bitmap_ram.sv =====
// Busy bitmap store: one write port, one read port with registered read data.
module nfcsa_bitmap_ram #(
  parameter int WORDS = (nfcsa_pkg::SLOTS_DEF + nfcsa_pkg::WORD_W - 1) / nfcsa_pkg::WORD_W
) (
  input  logic                                        clk,
  input  logic                                        rd_en,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_addr,
  output logic [nfcsa_pkg::WORD_W-1:0]                rd_data,
  input  logic                                        wr_en,
  input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_addr,
  input  logic [nfcsa_pkg::WORD_W-1:0]                wr_data
);

  logic [nfcsa_pkg::WORD_W-1:0] mem [WORDS];
  logic [nfcsa_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/nfcsa_seq.sv =====
// Sequencer: clearing pass, next-fit word search, and read-modify-write of bitmap runs.
module nfcsa_seq #(
  parameter int SLOTS = nfcsa_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [nfcsa_pkg::START_W-1:0]       in_start_index,
  input  logic [nfcsa_pkg::COUNT_W-1:0]       in_count,
  input  logic                                out_free,
  output nfcsa_pkg::res_t                     res,
  output logic                                rd_en,
  output logic [((((SLOTS + nfcsa_pkg::WORD_W - 1) / nfcsa_pkg::WORD_W) > 1) ?
                 $clog2((SLOTS + nfcsa_pkg::WORD_W - 1) / nfcsa_pkg::WORD_W) : 1)-1:0] rd_addr,
  input  logic [nfcsa_pkg::WORD_W-1:0]        rd_data,
  output logic                                wr_en,
  output logic [((((SLOTS + nfcsa_pkg::WORD_W - 1) / nfcsa_pkg::WORD_W) > 1) ?
                 $clog2((SLOTS + nfcsa_pkg::WORD_W - 1) / nfcsa_pkg::WORD_W) : 1)-1:0] wr_addr,
  output logic [nfcsa_pkg::WORD_W-1:0]        wr_data
);

  localparam int WORDS = (SLOTS + nfcsa_pkg::WORD_W - 1) / nfcsa_pkg::WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OW    = nfcsa_pkg::OFF_W;
  localparam int CW    = nfcsa_pkg::COUNT_W;
  localparam int PW    = AW + OW + 1;
  localparam int SUMW  = ((PW > CW) ? PW : CW) + 1;

  localparam logic [SUMW-1:0] SLOTS_S   = SUMW'(SLOTS);
  localparam logic [PW-1:0]   SLOTS_P   = PW'(SLOTS);
  localparam logic [AW-1:0]   LAST_WORD = AW'(WORDS - 1);
  localparam logic [OW-1:0]   OFF_MAX   = '1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_CAND, S_CHK, S_WRD, S_WWR, S_FIN
  } state_t;

  state_t                         state_r, state_nxt;
  logic [AW-1:0]                  k_r, k_nxt;
  logic [PW-1:0]                  ptr_r, ptr_nxt;
  logic [PW-1:0]                  c_r, c_nxt;
  logic [PW-1:0]                  e_r, e_nxt;
  logic [PW-1:0]                  q_r, q_nxt;
  logic [CW-1:0]                  n_r, n_nxt;
  logic                           pass_r, pass_nxt;
  logic                           set_r, set_nxt;
  logic                           held_vld_r, held_vld_nxt;
  logic [AW-1:0]                  held_addr_r, held_addr_nxt;
  nfcsa_pkg::status_t             st_r, st_nxt;
  logic [nfcsa_pkg::START_W-1:0]  gs_r, gs_nxt;
  logic [CW-1:0]                  gc_r, gc_nxt;

  logic [SUMW-1:0]                free_end;
  logic [SUMW-1:0]                cand_end;
  logic [AW-1:0]                  c_word, e_word, q_word;
  logic                           e_here;
  logic [nfcsa_pkg::WORD_W-1:0]   hit;
  logic [nfcsa_pkg::WORD_W-1:0]   wmask;
  logic [PW-1:0]                  past_run;
  logic                           accept;

  assign c_word   = c_r[OW+AW-1:OW];
  assign e_word   = e_r[OW+AW-1:OW];
  assign q_word   = q_r[OW+AW-1:OW];
  assign e_here   = (e_word == q_word);
  assign free_end = SUMW'(in_start_index) + SUMW'(in_count);
  assign cand_end = SUMW'(c_r) + SUMW'(n_r);
  assign hit      = rd_data & nfcsa_pkg::range_mask(q_r[OW-1:0],
                                                    e_here ? e_r[OW-1:0] : OFF_MAX);
  assign wmask    = nfcsa_pkg::range_mask((k_r == c_word) ? c_r[OW-1:0] : '0,
                                          (k_r == e_word) ? e_r[OW-1:0] : OFF_MAX);
  assign past_run = e_r + PW'(1);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  assign res.vld    = (state_r == S_FIN) && out_free;
  assign res.status = st_r;
  assign res.start  = gs_r;
  assign res.count  = gc_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    c_nxt         = c_r;
    e_nxt         = e_r;
    q_nxt         = q_r;
    n_nxt         = n_r;
    pass_nxt      = pass_r;
    set_nxt       = set_r;
    held_vld_nxt  = held_vld_r;
    held_addr_nxt = held_addr_r;
    st_nxt        = st_r;
    gs_nxt        = gs_r;
    gc_nxt        = gc_r;
    rd_en         = 1'b0;
    rd_addr       = k_r;
    wr_en         = 1'b0;
    wr_addr       = k_r;
    wr_data       = '0;

    case (state_r)
      S_CLR: begin
        wr_en = 1'b1;
        k_nxt = k_r + AW'(1);
        if (k_r == LAST_WORD) begin
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          st_nxt = nfcsa_pkg::ST_DONE;
          gs_nxt = '0;
          gc_nxt = '0;
          if (in_func == nfcsa_pkg::FUNC_FREE) begin
            if (free_end > SLOTS_S) begin
              st_nxt    = nfcsa_pkg::ST_RANGE;
              state_nxt = S_FIN;
            end else if (in_count == '0) begin
              state_nxt = S_FIN;
            end else begin
              gc_nxt       = in_count;
              c_nxt        = PW'(in_start_index);
              e_nxt        = PW'(free_end - SUMW'(1));
              k_nxt        = AW'(PW'(in_start_index) >> OW);
              set_nxt      = 1'b0;
              held_vld_nxt = 1'b0;
              state_nxt    = S_WRD;
            end
          end else if (in_count == '0) begin
            state_nxt = S_FIN;
          end else begin
            n_nxt     = in_count;
            c_nxt     = ptr_r;
            pass_nxt  = 1'b0;
            state_nxt = S_CAND;
          end
        end
      end

      // Vet the candidate start: wrap to slot 0 once, stop on reaching the pointer again.
      S_CAND: begin
        if (cand_end > SLOTS_S) begin
          if (!pass_r && (ptr_r != '0)) begin
            c_nxt    = '0;
            pass_nxt = 1'b1;
          end else begin
            st_nxt    = nfcsa_pkg::ST_NOSPACE;
            state_nxt = S_FIN;
          end
        end else if (pass_r && (c_r >= ptr_r)) begin
          st_nxt    = nfcsa_pkg::ST_NOSPACE;
          state_nxt = S_FIN;
        end else begin
          e_nxt     = PW'(cand_end - SUMW'(1));
          q_nxt     = c_r;
          state_nxt = S_CHK;
          if (!(held_vld_r && (held_addr_r == c_word))) begin
            rd_en         = 1'b1;
            rd_addr       = c_word;
            held_vld_nxt  = 1'b1;
            held_addr_nxt = c_word;
          end
        end
      end

      // Jump past the last busy slot in the word read from the span; every earlier conflict in it leads there too.
      S_CHK: begin
        if (hit != '0) begin
          c_nxt     = PW'({q_word, nfcsa_pkg::top_bit(hit)}) + PW'(1);
          state_nxt = S_CAND;
        end else if (e_here) begin
          gs_nxt       = nfcsa_pkg::START_W'(c_r);
          gc_nxt       = n_r;
          ptr_nxt      = (past_run == SLOTS_P) ? '0 : past_run;
          set_nxt      = 1'b1;
          k_nxt        = c_word;
          held_vld_nxt = 1'b0;
          state_nxt    = S_WRD;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = q_word + AW'(1);
          held_addr_nxt = q_word + AW'(1);
          q_nxt         = PW'({q_word + AW'(1), OW'(0)});
        end
      end

      S_WRD: begin
        rd_en     = 1'b1;
        rd_addr   = k_r;
        state_nxt = S_WWR;
      end

      S_WWR: begin
        wr_en   = 1'b1;
        wr_data = set_r ? (rd_data | wmask) : (rd_data & ~wmask);
        if (k_r == e_word) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = S_WRD;
        end
      end

      // Hold the result until the output register frees up.
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      k_r        <= '0;
      ptr_r      <= '0;
      pass_r     <= 1'b0;
      held_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      k_r        <= k_nxt;
      ptr_r      <= ptr_nxt;
      pass_r     <= pass_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r         <= c_nxt;
    e_r         <= e_nxt;
    q_r         <= q_nxt;
    n_r         <= n_nxt;
    set_r       <= set_nxt;
    held_addr_r <= held_addr_nxt;
    st_r        <= st_nxt;
    gs_r        <= gs_nxt;
    gc_r        <= gc_nxt;
  end

endmodule

// ===== sv/next_fit_contiguous_slot_allocator.sv =====
// One transaction at a time; in_stall stays high from acceptance until the result is handed to the output
// register. An allocate checks candidate starts (the first, one per busy-slot jump, the wrap to slot 0,
// a failing last), reads 32-slot bitmap words while searching (one per cycle), then marks the run by
// read-modify-write of each of its words. Free clears its words the same way; zero-count and out-of-range
// requests go straight to the result. While out_stall holds the output register full, the result waits.
// Reset: a clearing pass zeroes the bitmap with in_stall high; pointer 0.
module next_fit_contiguous_slot_allocator #(
  parameter int SLOTS = nfcsa_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_func,
  input  logic [nfcsa_pkg::START_W-1:0]    in_start_index,
  input  logic [nfcsa_pkg::COUNT_W-1:0]    in_count,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [nfcsa_pkg::STATUS_W-1:0]   out_status,
  output logic [nfcsa_pkg::START_W-1:0]    out_granted_start,
  output logic [nfcsa_pkg::COUNT_W-1:0]    out_granted_count
);

  localparam int WORDS = (SLOTS + nfcsa_pkg::WORD_W - 1) / nfcsa_pkg::WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  nfcsa_pkg::res_t                 res;
  logic                            out_free;
  logic                            rd_en, wr_en;
  logic [AW-1:0]                   rd_addr, wr_addr;
  logic [nfcsa_pkg::WORD_W-1:0]    rd_data, wr_data;

  logic                            out_valid_r;
  logic [nfcsa_pkg::STATUS_W-1:0]  out_status_r;
  logic [nfcsa_pkg::START_W-1:0]   out_start_r;
  logic [nfcsa_pkg::COUNT_W-1:0]   out_count_r;

  assign out_free = !out_valid_r || !out_stall;

  nfcsa_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_start_index (in_start_index),
    .in_count       (in_count),
    .out_free       (out_free),
    .res            (res),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

  nfcsa_bitmap_ram #(
    .WORDS(WORDS)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Output register: load a new result, or drop the old one once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.vld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_status_r <= res.status;
      out_start_r  <= res.start;
      out_count_r  <= res.count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_start = out_start_r;
  assign out_granted_count = out_count_r;

endmodule

// ===== dv/next_fit_contiguous_slot_allocator_tb.sv =====
// Self-checking testbench for the next-fit contiguous slot allocator.
`timescale 1ns / 100ps

module next_fit_contiguous_slot_allocator_tb;

  localparam int NSLOT = nfcsa_pkg::SLOTS_DEF;

  typedef struct {
    nfcsa_pkg::status_t            status;
    logic [nfcsa_pkg::START_W-1:0] start;
    logic [nfcsa_pkg::COUNT_W-1:0] count;
  } grant_t;

  typedef struct {
    logic                          func;
    logic [nfcsa_pkg::START_W-1:0] start_index;
    logic [nfcsa_pkg::COUNT_W-1:0] count;
    bit                            typed;
    grant_t                        want;
  } op_row_t;

  typedef struct {
    logic [nfcsa_pkg::START_W-1:0] start;
    logic [nfcsa_pkg::COUNT_W-1:0] count;
  } run_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_func = nfcsa_pkg::FUNC_ALLOC;
  logic [nfcsa_pkg::START_W-1:0]  in_start_index = '0;
  logic [nfcsa_pkg::COUNT_W-1:0]  in_count = '0;
  logic                           out_stall = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic [nfcsa_pkg::STATUS_W-1:0] out_status;
  logic [nfcsa_pkg::START_W-1:0]  out_granted_start;
  logic [nfcsa_pkg::COUNT_W-1:0]  out_granted_count;

  // Allocator mirror
  logic                          busy_map [NSLOT];
  logic [nfcsa_pkg::START_W-1:0] next_ptr;

  grant_t  pending_grants[$];
  run_t    held_runs[$];
  op_row_t directed_ops[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  next_fit_contiguous_slot_allocator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_start_index    (in_start_index),
    .in_count          (in_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_start (out_granted_start),
    .out_granted_count (out_granted_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("timeout at %0t, %0d results outstanding", $time, pending_grants.size());
    $display("== FAIL ==");
    $finish;
  end

  // Apply one transaction to the mirror and return the grant it produces.
  function automatic grant_t next_fit_grant(input logic f, input int si, input int n);
    grant_t g;
    int     walked;
    int     pos;
    int     s;
    bit     clear;
    g = '{nfcsa_pkg::ST_DONE, '0, '0};
    if (f == nfcsa_pkg::FUNC_FREE) begin
      if (si + n > NSLOT) begin
        g.status = nfcsa_pkg::ST_RANGE;
      end else begin
        for (int i = 0; i < n; i++) busy_map[si + i] = 1'b0;
        g.count = nfcsa_pkg::COUNT_W'(n);
      end
      return g;
    end
    if (n == 0) return g;
    walked = 0;
    while (walked < NSLOT) begin
      pos = (int'(next_ptr) + walked) % NSLOT;
      // run would cross the end: restart at slot 0
      if (pos + n > NSLOT) begin
        walked += NSLOT - pos;
        continue;
      end
      clear = 1'b1;
      s = 0;
      while (s < n && clear) begin
        if (busy_map[pos + s]) clear = 1'b0;
        else s++;
      end
      if (clear) begin
        for (int i = 0; i < n; i++) busy_map[pos + i] = 1'b1;
        next_ptr = nfcsa_pkg::START_W'((pos + n) % NSLOT);
        g.start = nfcsa_pkg::START_W'(pos);
        g.count = nfcsa_pkg::COUNT_W'(n);
        return g;
      end
      // skip past the busy slot
      walked += s + 1;
    end
    g.status = nfcsa_pkg::ST_NOSPACE;
    return g;
  endfunction

  task automatic send_op(input logic f, input logic [nfcsa_pkg::START_W-1:0] si,
                         input logic [nfcsa_pkg::COUNT_W-1:0] n, input bit typed,
                         input grant_t want);
    grant_t got;
    int     gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_start_index <= si;
    in_count       <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = next_fit_grant(f, si, n);
    if (f == nfcsa_pkg::FUNC_ALLOC && got.status == nfcsa_pkg::ST_DONE && n != 0)
      held_runs.push_back('{got.start, got.count});
    if (typed) pending_grants.push_back(want);
    else pending_grants.push_back(got);
  endtask

  // Mostly allocate and release held runs; the rest is stray frees, often out of range.
  task automatic make_item(output logic f, output logic [nfcsa_pkg::START_W-1:0] si,
                           output logic [nfcsa_pkg::COUNT_W-1:0] n);
    int   r;
    int   k;
    run_t held;
    r = $urandom_range(99);
    if (r < 50 || (r < 85 && held_runs.size() == 0)) begin
      f  = nfcsa_pkg::FUNC_ALLOC;
      si = nfcsa_pkg::START_W'($urandom);
      k  = $urandom_range(99);
      if (k < 2) n = '0;
      else if (k < 60) n = nfcsa_pkg::COUNT_W'($urandom_range(8, 1));
      else if (k < 85) n = nfcsa_pkg::COUNT_W'($urandom_range(64, 9));
      else if (k < 97) n = nfcsa_pkg::COUNT_W'($urandom_range(300, 65));
      else n = nfcsa_pkg::COUNT_W'($urandom_range(NSLOT, 301));
    end else if (r < 85) begin
      k    = $urandom_range(held_runs.size() - 1);
      held = held_runs[k];
      held_runs.delete(k);
      f  = nfcsa_pkg::FUNC_FREE;
      si = held.start;
      n  = held.count;
    end else begin
      f  = nfcsa_pkg::FUNC_FREE;
      si = nfcsa_pkg::START_W'($urandom_range(NSLOT - 1));
      if (r < 93) n = nfcsa_pkg::COUNT_W'($urandom_range(16));
      else n = nfcsa_pkg::COUNT_W'($urandom_range(NSLOT));
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (pending_grants.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual status %0d start %0d count %0d",
                 $time, out_status, out_granted_start, out_granted_count);
      end else begin
        want = pending_grants.pop_front();
        if (out_status !== want.status) begin
          mismatches++;
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, out_status);
        end
        if (out_granted_start !== want.start) begin
          mismatches++;
          $display("%0t: granted_start mismatch: expected %0d actual %0d",
                   $time, want.start, out_granted_start);
        end
        if (out_granted_count !== want.count) begin
          mismatches++;
          $display("%0t: granted_count mismatch: expected %0d actual %0d",
                   $time, want.count, out_granted_count);
        end
      end
    end
  end

  initial begin
    logic                          f;
    logic [nfcsa_pkg::START_W-1:0] si;
    logic [nfcsa_pkg::COUNT_W-1:0] n;
    grant_t                        none;
    int                            waited;

    none = '{nfcsa_pkg::ST_DONE, '0, '0};
    for (int i = 0; i < NSLOT; i++) busy_map[i] = 1'b0;
    next_ptr = '0;

    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd0,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd0}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd1,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd1}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'h3FF, 11'd1024,
                             1'b1, '{nfcsa_pkg::ST_NOSPACE, 10'd0, 11'd0}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd0, 11'd1,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd1}});
    // whole store fits once the search comes round to slot 0
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'h155, 11'd1024,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd1024}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'h2AA, 11'd1,
                             1'b1, '{nfcsa_pkg::ST_NOSPACE, 10'd0, 11'd0}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd0,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd0}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd1023, 11'd1,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd1}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd1, 1'b0, none});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd1, 11'd1024,
                             1'b1, '{nfcsa_pkg::ST_RANGE, 10'd0, 11'd0}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd1023, 11'd2,
                             1'b1, '{nfcsa_pkg::ST_RANGE, 10'd0, 11'd0}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd1023, 11'd0,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd0}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd0, 11'd1024,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd1024}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd512, 11'd0,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd0}});
    // slots already free stay free
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd0, 11'd5,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd5}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd1000, 1'b0, none});
    // run would cross the end, wrap finds nothing
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd30, 1'b0, none});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd24, 1'b0, none});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd10, 11'd20,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd20}});
    // hole too short: conflict skip across the whole store
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd25, 1'b0, none});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd20, 1'b0, none});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd1023, 11'd1,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd1}});
    directed_ops.push_back('{nfcsa_pkg::FUNC_ALLOC, 10'd0, 11'd1, 1'b0, none});
    directed_ops.push_back('{nfcsa_pkg::FUNC_FREE, 10'd0, 11'd1024,
                             1'b1, '{nfcsa_pkg::ST_DONE, 10'd0, 11'd1024}});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i])
      send_op(directed_ops[i].func, directed_ops[i].start_index, directed_ops[i].count,
              directed_ops[i].typed, directed_ops[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        2: begin
          send_idle_pct = 12;
          recv_stall_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (400) begin
        make_item(f, si, n);
        send_op(f, si, n, 1'b0, none);
      end
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    // drain, then give a late or extra result time to show up
    waited = 0;
    while (pending_grants.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_grants.size() != 0) begin
      mismatches += pending_grants.size();
      $display("%0t: %0d expected results never arrived", $time, pending_grants.size());
    end

    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
